[hw/rtl/php_pkg.sv]
package php_pkg;

    // Frame counter limit and the ICMP header size reported on a parsed beat.
    localparam logic [15:0] MAX_CAPTURE       = 16'd65535;
    localparam logic [6:0]  ICMP_HEADER_BYTES = 7'd4;

    // Default depth of the frame queue between front and back.
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Start layer codes.
    localparam logic [1:0] LAYER_ETH = 2'd2;
    localparam logic [1:0] LAYER_IP  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_START_LAYER = 2'd0;
    localparam logic [1:0] CFG_LINK_TYPE   = 2'd1;
    localparam logic [1:0] CFG_ALLOW_SHORT = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [1:0] START_LAYER_RESET = LAYER_ETH;
    localparam logic [7:0] LINK_TYPE_RESET   = 8'd1;
    localparam logic [7:0] LINK_ETHERNET     = 8'd1;

    // Protocol constants.
    localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
    localparam logic [15:0] ETYPE_ARP      = 16'h0806;
    localparam logic [15:0] FRAG_DF_ONLY   = 16'd16384;
    localparam logic [3:0]  IP_VERSION_4   = 4'd4;
    localparam logic [7:0]  PROTO_ICMP     = 8'd1;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    // Header sizes in bytes.
    localparam logic [6:0] ETH_BYTES       = 7'd14;
    localparam logic [6:0] ARP_BYTES       = 7'd28;
    localparam logic [6:0] IP_MIN_BYTES    = 7'd20;
    localparam logic [6:0] TCP_BYTES       = 7'd20;
    localparam logic [6:0] TCP_SHORT_BYTES = 7'd8;
    localparam logic [6:0] UDP_BYTES       = 7'd8;
    localparam logic [6:0] ICMP_NEED_BYTES = 7'd8;

    // Verdict codes.
    typedef enum logic [2:0] {
        ST_PARSED     = 3'd0,
        ST_NOT_PARSED = 3'd1,
        ST_SHORT_ETH  = 3'd2,
        ST_WRONG_LINK = 3'd3,
        ST_BAD_LAYER  = 3'd4
    } status_t;

    // Packet kinds.
    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_ARP  = 3'd1,
        KIND_TCP  = 3'd2,
        KIND_UDP  = 3'd3,
        KIND_ICMP = 3'd4
    } kind_t;

    // Everything the back end needs to judge one finished frame.
    typedef struct packed {
        logic [1:0]  start_layer;
        logic        link_ok;
        logic        allow_short;
        logic [15:0] len;
        logic [15:0] etype;
        logic [7:0]  ver_ihl;
        logic [15:0] total_len;
        logic [15:0] frag;
        logic [7:0]  proto;
    } frame_t;

    // Handshake between the front end and the queue.
    typedef struct packed {
        logic push;
        logic full;
    } qwr_t;

endpackage

[hw/rtl/php_if.sv]
// Byte input channel.
interface php_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Verdict output channel.
interface php_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [6:0]  header_bytes;
    logic [2:0]  packet_kind;
    logic        ip_options_present;
    logic [15:0] capture_length;

    modport source (output valid, output status, output header_bytes, output packet_kind,
                    output ip_options_present, output capture_length, input ready);
    modport sink   (input valid, input status, input header_bytes, input packet_kind,
                    input ip_options_present, input capture_length, output ready);
endinterface

// Configuration write channel.
interface php_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/packet_header_parser.sv]
// Channel  Modport  Beat                                         Accepted when
// in_ch    sink     data_byte, last_byte                         valid && ready
// out_ch   source   status, header_bytes, packet_kind,
//                   ip_options_present, capture_length           valid && ready
// cfg      sink     index, data                                  valid && ready
//
// One byte is accepted every cycle while the frame queue has room; the front end captures fields as bytes pass.
// After the last byte of a frame is taken, the frame waits in the frame queue; its verdict
// is then loaded into the back end's output register and is valid on out_ch from there.
// Reset loads the register defaults, clears the frame state and empties the queue.
// in_ch stalls only while the frame queue, which holds QUEUE_DEPTH frames, is full.
module packet_header_parser #(
    parameter int QUEUE_DEPTH = php_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    php_in_if.sink    in_ch,
    php_out_if.source out_ch,
    php_cfg_if.sink   cfg
);
    import php_pkg::*;

    qwr_t   q_wr;
    frame_t q_push_data;
    frame_t q_head;
    logic   q_full;
    logic   q_empty;
    logic   q_pop;

    // Byte capture and configuration registers.
    php_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .cfg    (cfg),
        .q_full (q_full),
        .q_wr   (q_wr),
        .q_data (q_push_data)
    );

    // Finished frames waiting for a verdict.
    php_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_wr      (q_wr),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    // Verdict and output register.
    php_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

endmodule

[hw/rtl/php_front.sv]
module php_front (
    input  logic            clk,
    input  logic            rst_n,
    php_in_if.sink          in_ch,
    php_cfg_if.sink         cfg,
    input  logic            q_full,
    output php_pkg::qwr_t   q_wr,
    output php_pkg::frame_t q_data
);
    import php_pkg::*;

    logic [1:0]  start_layer_reg;
    logic [7:0]  link_type_reg;
    logic        allow_short_reg;

    logic [15:0] count_reg, count_next;
    logic [15:0] etype_reg, etype_next;
    logic [7:0]  ver_ihl_reg, ver_ihl_next;
    logic [15:0] total_reg, total_next;
    logic [15:0] frag_reg, frag_next;
    logic [7:0]  proto_reg, proto_next;

    logic        accept;
    logic        is_eth;
    logic        is_ip;
    logic [15:0] base;
    logic [15:0] rel;
    logic        in_ip_hdr;
    logic [15:0] count_sat;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_layer_reg <= START_LAYER_RESET;
            link_type_reg   <= LINK_TYPE_RESET;
            allow_short_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_START_LAYER: start_layer_reg <= cfg.data[1:0];
                CFG_LINK_TYPE:   link_type_reg   <= cfg.data;
                CFG_ALLOW_SHORT: allow_short_reg <= cfg.data[0];
                default:         ;
            endcase
        end
    end

    // A byte is taken whenever the queue has room for a finished frame.
    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && !q_full;

    // Field capture at fixed offsets, merged with the byte on the channel.
    always_comb
    begin
        is_eth     = (start_layer_reg == LAYER_ETH);
        is_ip      = (start_layer_reg == LAYER_IP);
        base       = is_eth ? {9'd0, ETH_BYTES} : 16'd0;
        in_ip_hdr  = (is_eth || is_ip) && (count_reg >= base);
        rel        = count_reg - base;
        count_sat  = (count_reg < MAX_CAPTURE) ? count_reg + 16'd1 : count_reg;

        etype_next   = etype_reg;
        ver_ihl_next = ver_ihl_reg;
        total_next   = total_reg;
        frag_next    = frag_reg;
        proto_next   = proto_reg;

        if (is_eth && count_reg == 16'd12)
        begin
            etype_next[15:8] = in_ch.data_byte;
        end
        if (is_eth && count_reg == 16'd13)
        begin
            etype_next[7:0] = in_ch.data_byte;
        end
        if (in_ip_hdr)
        begin
            case (rel)
                16'd0:   ver_ihl_next     = in_ch.data_byte;
                16'd2:   total_next[15:8] = in_ch.data_byte;
                16'd3:   total_next[7:0]  = in_ch.data_byte;
                16'd6:   frag_next[15:8]  = in_ch.data_byte;
                16'd7:   frag_next[7:0]   = in_ch.data_byte;
                16'd9:   proto_next       = in_ch.data_byte;
                default: ;
            endcase
        end
        count_next = count_sat;
    end

    // The finished frame record goes to the queue on the last beat.
    always_comb
    begin
        q_wr.push          = accept && in_ch.last_byte;
        q_wr.full          = q_full;
        q_data.start_layer = start_layer_reg;
        q_data.link_ok     = (link_type_reg == LINK_ETHERNET);
        q_data.allow_short = allow_short_reg;
        q_data.len         = count_next;
        q_data.etype       = etype_next;
        q_data.ver_ihl     = ver_ihl_next;
        q_data.total_len   = total_next;
        q_data.frag        = frag_next;
        q_data.proto       = proto_next;
    end

    // Per-frame state, cleared after the last beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= 16'd0;
            etype_reg   <= 16'd0;
            ver_ihl_reg <= 8'd0;
            total_reg   <= 16'd0;
            frag_reg    <= 16'd0;
            proto_reg   <= 8'd0;
        end
        else if (accept)
        begin
            if (in_ch.last_byte)
            begin
                count_reg   <= 16'd0;
                etype_reg   <= 16'd0;
                ver_ihl_reg <= 8'd0;
                total_reg   <= 16'd0;
                frag_reg    <= 16'd0;
                proto_reg   <= 8'd0;
            end
            else
            begin
                count_reg   <= count_next;
                etype_reg   <= etype_next;
                ver_ihl_reg <= ver_ihl_next;
                total_reg   <= total_next;
                frag_reg    <= frag_next;
                proto_reg   <= proto_next;
            end
        end
    end

endmodule

[hw/rtl/php_queue.sv]
module php_queue #(
    parameter int DEPTH = php_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  php_pkg::qwr_t   q_wr,
    input  php_pkg::frame_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output php_pkg::frame_t head
);
    import php_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    frame_t        entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (cnt_reg == FULL_CNT);
    assign empty   = (cnt_reg == '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = q_wr.push;
    assign do_pop  = pop && !empty;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (!do_push && do_pop)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_wr.full |-> !q_wr.push)
        else $error("frame pushed into a full queue");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL_CNT)
        else $error("queue fill count out of range");
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (cnt_reg == $past(cnt_reg) + CW'(1)))
        else $error("queue lost a pushed frame");
`endif

endmodule

[hw/rtl/php_back.sv]
module php_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  php_pkg::frame_t q_head,
    output logic            q_pop,
    php_out_if.source       out_ch
);
    import php_pkg::*;

    logic        out_valid_reg;
    status_t     status_reg, status_next;
    logic [6:0]  hdr_reg, hdr_next;
    kind_t       kind_reg, kind_next;
    logic        opts_reg, opts_next;
    logic [15:0] len_reg;

    logic        is_eth;
    logic [6:0]  l2;
    logic [6:0]  ihl_bytes;
    logic [6:0]  need;
    logic [6:0]  l4;
    kind_t       l4_kind;
    logic        proto_ok;
    logic        frag_bad;
    logic [16:0] len17;
    logic [16:0] lim_ip_min;
    logic [16:0] lim_total;
    logic [16:0] lim_ihl;
    logic [16:0] lim_l4;

    // Transport protocol decode.
    always_comb
    begin
        need     = UDP_BYTES;
        l4       = UDP_BYTES;
        l4_kind  = KIND_NONE;
        proto_ok = 1'b1;
        unique case (q_head.proto)
            PROTO_TCP:
            begin
                need    = q_head.allow_short ? TCP_SHORT_BYTES : TCP_BYTES;
                l4      = need;
                l4_kind = KIND_TCP;
            end
            PROTO_UDP:
            begin
                l4_kind = KIND_UDP;
            end
            PROTO_ICMP:
            begin
                need    = ICMP_NEED_BYTES;
                l4      = ICMP_HEADER_BYTES;
                l4_kind = KIND_ICMP;
            end
            default:
            begin
                proto_ok = 1'b0;
            end
        endcase
    end

    // Length limits against which the capture length is checked, and the fragment check.
    always_comb
    begin
        is_eth     = (q_head.start_layer == LAYER_ETH);
        l2         = is_eth ? ETH_BYTES : 7'd0;
        ihl_bytes  = {1'b0, q_head.ver_ihl[3:0], 2'b00};
        len17      = {1'b0, q_head.len};
        lim_ip_min = {10'd0, l2} + {10'd0, IP_MIN_BYTES};
        lim_total  = {10'd0, l2} + {1'b0, q_head.total_len};
        lim_ihl    = {10'd0, l2} + {10'd0, ihl_bytes};
        lim_l4     = lim_ihl + {10'd0, need};
        frag_bad   = (q_head.frag != 16'd0) && (q_head.frag != FRAG_DF_ONLY);
    end

    // Verdict, checked in order of precedence.
    always_comb
    begin
        status_next = ST_NOT_PARSED;
        hdr_next    = 7'd0;
        kind_next   = KIND_NONE;
        opts_next   = 1'b0;
        if (!is_eth && q_head.start_layer != LAYER_IP)
        begin
            status_next = ST_BAD_LAYER;
        end
        else if (is_eth && !q_head.link_ok)
        begin
            status_next = ST_WRONG_LINK;
        end
        else if (is_eth && len17 < {10'd0, ETH_BYTES})
        begin
            status_next = ST_SHORT_ETH;
        end
        else if (is_eth && q_head.etype == ETYPE_ARP)
        begin
            if (len17 >= {10'd0, ETH_BYTES} + {10'd0, ARP_BYTES})
            begin
                status_next = ST_PARSED;
                hdr_next    = ETH_BYTES + ARP_BYTES;
                kind_next   = KIND_ARP;
            end
        end
        else if (is_eth && q_head.etype != ETYPE_IPV4)
        begin
            status_next = ST_NOT_PARSED;
        end
        else if (len17 < lim_ip_min || frag_bad)
        begin
            status_next = ST_NOT_PARSED;
        end
        else if (q_head.ver_ihl[7:4] != IP_VERSION_4 || ihl_bytes < IP_MIN_BYTES)
        begin
            status_next = ST_NOT_PARSED;
        end
        else if ((len17 < lim_total && !q_head.allow_short) || len17 < lim_ihl)
        begin
            status_next = ST_NOT_PARSED;
        end
        else if (!proto_ok || len17 < lim_l4)
        begin
            status_next = ST_NOT_PARSED;
        end
        else
        begin
            status_next = ST_PARSED;
            hdr_next    = l2 + ihl_bytes + l4;
            kind_next   = l4_kind;
            opts_next   = (ihl_bytes > IP_MIN_BYTES);
        end
    end

    // The output register refills from the queue whenever a frame waits and the register is empty or being drained.
    assign q_pop = !q_empty && (!out_valid_reg || out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            status_reg <= status_next;
            hdr_reg    <= hdr_next;
            kind_reg   <= kind_next;
            opts_reg   <= opts_next;
            len_reg    <= q_head.len;
        end
    end

    assign out_ch.valid              = out_valid_reg;
    assign out_ch.status             = status_reg;
    assign out_ch.header_bytes       = hdr_reg;
    assign out_ch.packet_kind        = kind_reg;
    assign out_ch.ip_options_present = opts_reg;
    assign out_ch.capture_length     = len_reg;

`ifndef SYNTHESIS
    a_parsed_has_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_PARSED) |-> (kind_reg != KIND_NONE))
        else $error("parsed verdict without a packet kind");
    a_unparsed_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_PARSED) |->
        (hdr_reg == 7'd0 && kind_reg == KIND_NONE && !opts_reg))
        else $error("unparsed verdict carries header details");
    a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> out_valid_reg)
        else $error("popped frame did not reach the output register");
`endif

endmodule
